### sv/ptc_pkg.sv
// ptc_pkg: shared types, event and register codes, and lookup tables
// for the pulse tone channel. No dependencies.
`default_nettype none
package ptc_pkg;

   // duty sequencer length and default lowest audible period
   localparam int DUTY_STEPS     = 8;
   localparam int DUTY_W         = $clog2(DUTY_STEPS);
   localparam int MIN_PERIOD_DEF = 8;
   localparam int PERIOD_W       = 11;

   // event codes
   localparam logic [2:0] ACT_WRITE   = 3'd0;
   localparam logic [2:0] ACT_TIMER   = 3'd1;
   localparam logic [2:0] ACT_QUARTER = 3'd2;
   localparam logic [2:0] ACT_HALF    = 3'd3;
   localparam logic [2:0] ACT_ENABLE  = 3'd4;

   // channel register selects
   localparam logic [1:0] REG_DUTY_VOL    = 2'd0;
   localparam logic [1:0] REG_SWEEP       = 2'd1;
   localparam logic [1:0] REG_PERIOD_LOW  = 2'd2;
   localparam logic [1:0] REG_PERIOD_HIGH = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] reg_select;
      logic [7:0] write_data;
      logic       enable_value;
   } req_type;

   typedef struct packed {
      logic [3:0] sample;
      logic       length_active;
   } rsp_type;

   // waveform pattern for each duty setting
   function automatic logic [7:0] duty_mask(input logic [1:0] duty);
      logic [7:0] mask;
      case (duty)
         2'd0:    mask = 8'h80;
         2'd1:    mask = 8'hC0;
         2'd2:    mask = 8'hF0;
         default: mask = 8'h3F;
      endcase
      return mask;
   endfunction

   // length counter load values
   function automatic logic [7:0] length_load(input logic [4:0] idx);
      logic [7:0] val;
      case (idx)
         5'd0:    val = 8'd10;
         5'd1:    val = 8'd254;
         5'd2:    val = 8'd20;
         5'd3:    val = 8'd2;
         5'd4:    val = 8'd40;
         5'd5:    val = 8'd4;
         5'd6:    val = 8'd80;
         5'd7:    val = 8'd6;
         5'd8:    val = 8'd160;
         5'd9:    val = 8'd8;
         5'd10:   val = 8'd60;
         5'd11:   val = 8'd10;
         5'd12:   val = 8'd14;
         5'd13:   val = 8'd12;
         5'd14:   val = 8'd26;
         5'd15:   val = 8'd14;
         5'd16:   val = 8'd12;
         5'd17:   val = 8'd16;
         5'd18:   val = 8'd24;
         5'd19:   val = 8'd18;
         5'd20:   val = 8'd48;
         5'd21:   val = 8'd20;
         5'd22:   val = 8'd96;
         5'd23:   val = 8'd22;
         5'd24:   val = 8'd192;
         5'd25:   val = 8'd24;
         5'd26:   val = 8'd72;
         5'd27:   val = 8'd26;
         5'd28:   val = 8'd16;
         5'd29:   val = 8'd28;
         5'd30:   val = 8'd32;
         default: val = 8'd30;
      endcase
      return val;
   endfunction

endpackage
`default_nettype wire

### sv/ptc_core.sv
// ptc_core: channel registers, timer, sequencer, sweep, length and envelope
// state, updated by one event per step. Depends on ptc_pkg.
`default_nettype none
module ptc_core #(
   parameter int MIN_PERIOD = ptc_pkg::MIN_PERIOD_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   input  wire logic             step_en,
   input  wire ptc_pkg::req_type step_req,
   output ptc_pkg::rsp_type      step_rsp
);

   localparam int PW = ptc_pkg::PERIOD_W;
   localparam int DW = ptc_pkg::DUTY_W;
   localparam logic [PW-1:0] MIN_P = PW'(MIN_PERIOD);

   logic          ntc_ff;
   logic [7:0]    duty_vol_ff, duty_vol_in;
   logic [7:0]    sweep_ff, sweep_in;
   logic [7:0]    per_low_ff, per_low_in;
   logic [7:0]    per_high_ff, per_high_in;
   logic [PW-1:0] timer_ff, timer_in;
   logic [7:0]    length_ff, length_in;
   logic [DW-1:0] duty_step_ff, duty_step_in;
   logic [2:0]    sweep_div_ff, sweep_div_in;
   logic          sweep_reload_ff, sweep_reload_in;
   logic          silenced_ff, silenced_in;
   logic          env_start_ff, env_start_in;
   logic [3:0]    env_div_ff, env_div_in;
   logic [3:0]    env_decay_ff, env_decay_in;

   logic [PW-1:0] cur_period;
   logic [PW-1:0] new_period;
   logic [15:0]   change;
   logic [15:0]   target;
   logic          muting;
   logic [3:0]    level;
   logic [7:0]    mask;

   assign cur_period = {per_high_ff[2:0], per_low_ff};

   // sweep target, 16-bit wrap like the original adder
   always_comb begin
      change = 16'(cur_period >> sweep_ff[2:0]);
      if (sweep_ff[3]) begin
         target = 16'(cur_period) + ~change + 16'(ntc_ff);
      end else begin
         target = 16'(cur_period) + change;
      end
      muting     = (cur_period < MIN_P) || (target > 16'h07FF);
      new_period = target[PW-1:0];
   end

   // next state for the event in the input register
   always_comb begin
      duty_vol_in     = duty_vol_ff;
      sweep_in        = sweep_ff;
      per_low_in      = per_low_ff;
      per_high_in     = per_high_ff;
      timer_in        = timer_ff;
      length_in       = length_ff;
      duty_step_in    = duty_step_ff;
      sweep_div_in    = sweep_div_ff;
      sweep_reload_in = sweep_reload_ff;
      silenced_in     = silenced_ff;
      env_start_in    = env_start_ff;
      env_div_in      = env_div_ff;
      env_decay_in    = env_decay_ff;
      case (step_req.action)
         ptc_pkg::ACT_WRITE: begin
            case (step_req.reg_select)
               ptc_pkg::REG_DUTY_VOL: duty_vol_in = step_req.write_data;
               ptc_pkg::REG_SWEEP: begin
                  sweep_in        = step_req.write_data;
                  sweep_reload_in = 1'b1;
               end
               ptc_pkg::REG_PERIOD_LOW: per_low_in = step_req.write_data;
               default: begin
                  per_high_in = step_req.write_data;
                  if (!silenced_ff) begin
                     length_in = ptc_pkg::length_load(step_req.write_data[7:3]);
                  end
                  duty_step_in = '0;
                  env_start_in = 1'b1;
               end
            endcase
         end
         ptc_pkg::ACT_TIMER: begin
            if (timer_ff == '0) begin
               duty_step_in = duty_step_ff - DW'(1);
               timer_in     = cur_period;
            end else begin
               timer_in = timer_ff - PW'(1);
            end
         end
         ptc_pkg::ACT_QUARTER: begin
            // envelope: start, divider reload with decay, or count down
            if (env_start_ff) begin
               env_start_in = 1'b0;
               env_decay_in = 4'd15;
               env_div_in   = duty_vol_ff[3:0];
            end else if (env_div_ff == 4'd0) begin
               env_div_in = duty_vol_ff[3:0];
               if (env_decay_ff != 4'd0) begin
                  env_decay_in = env_decay_ff - 4'd1;
               end else if (duty_vol_ff[5]) begin
                  env_decay_in = 4'd15;
               end
            end else begin
               env_div_in = env_div_ff - 4'd1;
            end
         end
         ptc_pkg::ACT_HALF: begin
            // sweep period update
            if (sweep_div_ff == 3'd0 && sweep_ff[7] && sweep_ff[2:0] != 3'd0 && !muting) begin
               per_low_in  = new_period[7:0];
               per_high_in = {per_high_ff[7:3], new_period[PW-1:8]};
            end
            if (sweep_div_ff == 3'd0 || sweep_reload_ff) begin
               sweep_reload_in = 1'b0;
               sweep_div_in    = sweep_ff[6:4];
            end else begin
               sweep_div_in = sweep_div_ff - 3'd1;
            end
            // length counter unless halted
            if (!duty_vol_ff[5] && length_ff != 8'd0) begin
               length_in = length_ff - 8'd1;
            end
         end
         ptc_pkg::ACT_ENABLE: begin
            if (step_req.enable_value) begin
               silenced_in = 1'b0;
            end else begin
               silenced_in = 1'b1;
               length_in   = 8'd0;
            end
         end
         default: begin
         end
      endcase
   end

   // sample taken from the state after the event
   always_comb begin
      level = duty_vol_in[4] ? duty_vol_in[3:0] : env_decay_in;
      mask  = ptc_pkg::duty_mask(duty_vol_in[7:6]);
      step_rsp.length_active = (length_in != 8'd0);
      if (length_in != 8'd0 && {per_high_in[2:0], per_low_in} >= MIN_P
          && mask[duty_step_in]) begin
         step_rsp.sample = level;
      end else begin
         step_rsp.sample = 4'd0;
      end
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         ntc_ff <= 1'b0;
      end else if (csr_write_enable) begin
         ntc_ff <= csr_write_data;
      end
   end

   // channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         duty_vol_ff     <= '0;
         sweep_ff        <= '0;
         per_low_ff      <= '0;
         per_high_ff     <= '0;
         timer_ff        <= '0;
         length_ff       <= '0;
         duty_step_ff    <= '0;
         sweep_div_ff    <= '0;
         sweep_reload_ff <= 1'b0;
         silenced_ff     <= 1'b1;
         env_start_ff    <= 1'b0;
         env_div_ff      <= '0;
         env_decay_ff    <= '0;
      end else if (step_en) begin
         duty_vol_ff     <= duty_vol_in;
         sweep_ff        <= sweep_in;
         per_low_ff      <= per_low_in;
         per_high_ff     <= per_high_in;
         timer_ff        <= timer_in;
         length_ff       <= length_in;
         duty_step_ff    <= duty_step_in;
         sweep_div_ff    <= sweep_div_in;
         sweep_reload_ff <= sweep_reload_in;
         silenced_ff     <= silenced_in;
         env_start_ff    <= env_start_in;
         env_div_ff      <= env_div_in;
         env_decay_ff    <= env_decay_in;
      end
   end

   // a disable clears the length counter
   a_disable_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && step_req.action == ptc_pkg::ACT_ENABLE && !step_req.enable_value)
      |=> (length_ff == 8'd0 && silenced_ff))
      else $error("length counter not cleared by disable");

endmodule
`default_nettype wire

### sv/pulse_tone_channel.sv
// Pulse tone channel: input register, single-pass state update, result register.
// A request is registered in the input register and its result in the result register.
// Throughput: one event per cycle unless a finished result waits under rsp_stall;
// then the input register holds one more event and further requests are stalled.
// Reset (synchronous): both stages empty, channel state cleared, channel silenced.
// Depends on ptc_pkg and ptc_core.
`default_nettype none
module pulse_tone_channel #(
   parameter int MIN_PERIOD = ptc_pkg::MIN_PERIOD_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_write_data,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ptc_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output ptc_pkg::rsp_type      rsp_payload
);

   logic             in_valid_ff, in_valid_in;
   ptc_pkg::req_type in_req_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   ptc_pkg::rsp_type rsp_ff;
   ptc_pkg::rsp_type core_rsp;
   logic             req_xfer;
   logic             advance;

   // stage control
   assign advance   = in_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_xfer || (in_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);
   end

   ptc_core #(
      .MIN_PERIOD(MIN_PERIOD)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .step_en          (advance),
      .step_req         (in_req_ff),
      .step_rsp         (core_rsp)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_req_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // both stages empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("pipeline not empty after reset");

   // a held event moves to the result register once it is free
   a_advance: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !(rsp_valid_ff && rsp_stall)) |=> rsp_valid_ff)
      else $error("event not moved to result register");

   // no sound without an active length counter
   a_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.length_active || rsp_ff.sample == 4'd0))
      else $error("sample nonzero with length counter at zero");

endmodule
`default_nettype wire

### test/ptc_sample_checker.sv
// ptc_sample_checker: watches the pulse tone channel's request, result and csr ports,
// predicts each output sample and length flag, and compares them in order.
// Depends on ptc_pkg for the transfer types and the event and register codes.
`timescale 1ns / 100ps
module ptc_sample_checker
   import ptc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    csr_write_enable,
   input  logic    csr_write_data,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_payload,
   output int      sample_mismatches,
   output int      samples_checked,
   output int      samples_pending
);

   localparam int MIN_PERIOD = MIN_PERIOD_DEF;

   // length counter load values, entry 0 rightmost
   localparam logic [31:0][7:0] LENGTH_LOADS = {
      8'd30, 8'd32, 8'd28, 8'd16, 8'd26, 8'd72, 8'd24, 8'd192,
      8'd22, 8'd96, 8'd20, 8'd48, 8'd18, 8'd24, 8'd16, 8'd12,
      8'd14, 8'd26, 8'd12, 8'd14, 8'd10, 8'd60, 8'd8, 8'd160,
      8'd6, 8'd80, 8'd4, 8'd40, 8'd2, 8'd20, 8'd254, 8'd10
   };

   // waveform per duty setting, indexed by sequencer step
   localparam logic [3:0][7:0] DUTY_PATTERNS = {8'h3F, 8'hF0, 8'hC0, 8'h80};

   // predicted channel state
   logic        negate_exact;
   logic [7:0]  duty_vol;
   logic [7:0]  sweep_ctl;
   logic [7:0]  period_lo;
   logic [7:0]  period_hi_len;
   logic [10:0] timer_count;
   logic [7:0]  length_left;
   logic [2:0]  seq_step;
   logic [2:0]  sweep_count;
   logic        sweep_reload_pending;
   logic        channel_off;
   logic        env_restart;
   logic [3:0]  env_count;
   logic [3:0]  env_level;

   rsp_type expected_samples[$];
   rsp_type oldest;

   initial begin
      sample_mismatches = 0;
      samples_checked   = 0;
      samples_pending   = 0;
   end

   function automatic logic [10:0] channel_period();
      return {period_hi_len[2:0], period_lo};
   endfunction

   // apply one event to the predicted state and return the resulting output
   function automatic rsp_type channel_sample_after(input req_type ev);
      logic [10:0] period;
      logic [15:0] change;
      logic [15:0] target;
      rsp_type     res;
      case (ev.action)
         ACT_WRITE: begin
            case (ev.reg_select)
               REG_DUTY_VOL: duty_vol = ev.write_data;
               REG_SWEEP: begin
                  sweep_ctl            = ev.write_data;
                  sweep_reload_pending = 1'b1;
               end
               REG_PERIOD_LOW: period_lo = ev.write_data;
               default: begin
                  period_hi_len = ev.write_data;
                  // length only loads while the channel is enabled
                  if (!channel_off)
                     length_left = LENGTH_LOADS[ev.write_data[7:3]];
                  seq_step    = '0;
                  env_restart = 1'b1;
               end
            endcase
         end
         ACT_TIMER: begin
            if (timer_count == 0) begin
               seq_step    = seq_step - 3'd1;
               timer_count = channel_period();
            end else begin
               timer_count = timer_count - 11'd1;
            end
         end
         ACT_QUARTER: begin
            // decay envelope
            if (env_restart) begin
               env_restart = 1'b0;
               env_level   = 4'd15;
               env_count   = duty_vol[3:0];
            end else if (env_count == 0) begin
               env_count = duty_vol[3:0];
               if (env_level != 0)
                  env_level = env_level - 4'd1;
               else if (duty_vol[5])
                  env_level = 4'd15;
            end else begin
               env_count = env_count - 4'd1;
            end
         end
         ACT_HALF: begin
            // sweep unit; muting only blocks the period update
            if (sweep_count == 0 && sweep_ctl[7] && sweep_ctl[2:0] != 0) begin
               period = channel_period();
               change = {5'b0, period} >> sweep_ctl[2:0];
               if (sweep_ctl[3])
                  target = {5'b0, period} - change - (negate_exact ? 16'd0 : 16'd1);
               else
                  target = {5'b0, period} + change;
               if (period >= MIN_PERIOD && target <= 16'h07FF) begin
                  period_lo          = target[7:0];
                  period_hi_len[2:0] = target[10:8];
               end
            end
            if (sweep_count == 0 || sweep_reload_pending) begin
               sweep_reload_pending = 1'b0;
               sweep_count          = sweep_ctl[6:4];
            end else begin
               sweep_count = sweep_count - 3'd1;
            end
            // length counter, frozen by the halt bit
            if (!duty_vol[5] && length_left != 0)
               length_left = length_left - 8'd1;
         end
         ACT_ENABLE: begin
            if (ev.enable_value) begin
               channel_off = 1'b0;
            end else begin
               channel_off = 1'b1;
               length_left = '0;
            end
         end
         default: ;
      endcase

      res.length_active = (length_left != 0);
      res.sample        = '0;
      if (length_left != 0 && channel_period() >= MIN_PERIOD &&
          DUTY_PATTERNS[duty_vol[7:6]][seq_step])
         res.sample = duty_vol[4] ? duty_vol[3:0] : env_level;
      return res;
   endfunction

   // predict on each request transfer, compare on each result transfer
   always @(posedge clock) begin
      if (reset) begin
         negate_exact         = 1'b0;
         duty_vol             = '0;
         sweep_ctl            = '0;
         period_lo            = '0;
         period_hi_len        = '0;
         timer_count          = '0;
         length_left          = '0;
         seq_step             = '0;
         sweep_count          = '0;
         sweep_reload_pending = 1'b0;
         channel_off          = 1'b1;
         env_restart          = 1'b0;
         env_count            = '0;
         env_level            = '0;
         expected_samples.delete();
         samples_pending <= 0;
      end else begin
         if (csr_write_enable)
            negate_exact = csr_write_data;
         if (req_valid && !req_stall)
            expected_samples.push_back(channel_sample_after(req_payload));
         if (rsp_valid && !rsp_stall) begin
            if (expected_samples.size() == 0) begin
               sample_mismatches++;
               $display("%0t: unexpected result transfer, expected none, got sample %0d len %0b",
                        $time, rsp_payload.sample, rsp_payload.length_active);
            end else begin
               oldest = expected_samples.pop_front();
               samples_checked++;
               if (rsp_payload.sample !== oldest.sample) begin
                  sample_mismatches++;
                  $display("%0t: sample mismatch, expected %0d, got %0d",
                           $time, oldest.sample, rsp_payload.sample);
               end
               if (rsp_payload.length_active !== oldest.length_active) begin
                  sample_mismatches++;
                  $display("%0t: length_active mismatch, expected %0b, got %0b",
                           $time, oldest.length_active, rsp_payload.length_active);
               end
            end
         end
         samples_pending <= expected_samples.size();
      end
   end

endmodule

### test/tb_pulse_tone_channel.sv
// tb_pulse_tone_channel: clock, reset, event stimulus and verdict for pulse_tone_channel.
// Depends on ptc_pkg, the channel RTL and ptc_sample_checker for prediction and compare.
`timescale 1ns / 100ps
module tb_pulse_tone_channel;
   import ptc_pkg::*;

   // action codes the channel ignores
   localparam logic [2:0] ACT_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] ACT_RESERVED_LAST  = 3'd7;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 8;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    csr_write_enable = 1'b0;
   logic    csr_write_data = 1'b0;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   int sample_mismatches;
   int samples_checked;
   int samples_pending;

   int idle_pct  = 8;
   int stall_pct = 8;
   int hold_off_requests = 0;
   int hold_offs_done = 0;
   int events_sent = 0;
   int settings_used = 0;

   always #5 clock = ~clock;

   pulse_tone_channel u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload)
   );

   ptc_sample_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_payload       (rsp_payload),
      .sample_mismatches (sample_mismatches),
      .samples_checked   (samples_checked),
      .samples_pending   (samples_pending)
   );

   // watchdog
   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls, plus a long hold-off when one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_requests > hold_offs_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_offs_done++;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic req_type make_event(input logic [2:0] act, input logic [1:0] sel,
                                          input logic [7:0] data, input logic en);
      req_type ev;
      ev.action       = act;
      ev.reg_select   = sel;
      ev.write_data   = data;
      ev.enable_value = en;
      return ev;
   endfunction

   // random event, weighted toward timer ticks and short periods so the
   // sequencer, envelope and sweep all get exercised with length loaded
   function automatic req_type random_event();
      req_type ev;
      int      pick;
      ev.action       = ACT_TIMER;
      ev.reg_select   = 2'($urandom_range(3));
      ev.write_data   = 8'($urandom_range(255));
      ev.enable_value = ($urandom_range(99) < 85);
      pick = $urandom_range(99);
      if (pick < 20) begin
         ev.action = ACT_WRITE;
         if (ev.reg_select == REG_PERIOD_HIGH && $urandom_range(99) < 70)
            ev.write_data[2:0] = '0;
         if (ev.reg_select == REG_PERIOD_LOW && $urandom_range(99) < 60)
            ev.write_data = 8'($urandom_range(40));
      end else if (pick < 65) begin
         ev.action = ACT_TIMER;
      end else if (pick < 77) begin
         ev.action = ACT_QUARTER;
      end else if (pick < 89) begin
         ev.action = ACT_HALF;
      end else if (pick < 97) begin
         ev.action = ACT_ENABLE;
      end else begin
         ev.action = 3'($urandom_range(ACT_RESERVED_LAST, ACT_RESERVED_FIRST));
      end
      return ev;
   endfunction

   // one request transfer, with random idle cycles ahead of it
   task automatic send_event(input req_type ev);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= ev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      events_sent++;
   endtask

   // stop offering and wait until every predicted sample has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (samples_pending != 0) @(posedge clock);
   endtask

   task automatic write_config(input logic negate_exact);
      csr_write_enable <= 1'b1;
      csr_write_data   <= negate_exact;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: ones-complement negate, field extremes, muting, ignored events
      write_config(1'b0);
      send_event(make_event(ACT_ENABLE, REG_DUTY_VOL, 8'h00, 1'b1));
      send_event(make_event(ACT_WRITE, REG_DUTY_VOL, 8'hFF, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_LOW, 8'h08, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_HIGH, 8'h08, 1'b0));
      send_event(make_event(ACT_TIMER, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_TIMER, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_QUARTER, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      // negate sweep pulls the period below the audible minimum
      send_event(make_event(ACT_WRITE, REG_SWEEP, 8'hFF, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_HIGH, 8'hFF, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_LOW, 8'hFF, 1'b0));
      // upward sweep from the top period overflows and is muted
      send_event(make_event(ACT_WRITE, REG_SWEEP, 8'h81, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      // zero shift never moves the period
      send_event(make_event(ACT_WRITE, REG_SWEEP, 8'h88, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      // envelope mode without halt, so length counts down
      send_event(make_event(ACT_WRITE, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_HALF, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_QUARTER, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_RESERVED_FIRST, REG_PERIOD_HIGH, 8'hFF, 1'b1));
      send_event(make_event(ACT_RESERVED_LAST, REG_PERIOD_HIGH, 8'hFF, 1'b1));
      // length load is ignored while disabled
      send_event(make_event(ACT_ENABLE, REG_DUTY_VOL, 8'h00, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_HIGH, 8'hF8, 1'b0));
      send_event(make_event(ACT_WRITE, REG_PERIOD_LOW, 8'h07, 1'b0));
      send_event(make_event(ACT_ENABLE, REG_DUTY_VOL, 8'h00, 1'b1));
      drain_results();

      // exact negate, with a long output hold-off while requests keep coming
      write_config(1'b1);
      hold_off_requests++;
      repeat (700) send_event(random_event());
      drain_results();

      // ones-complement negate, with a full drain pause in the middle
      write_config(1'b0);
      repeat (350) send_event(random_event());
      drain_results();
      repeat (350) send_event(random_event());
      drain_results();

      // exact negate: back-to-back stretch first, then random idling again
      write_config(1'b1);
      idle_pct  = 0;
      stall_pct = 0;
      repeat (300) send_event(random_event());
      idle_pct  = 8;
      stall_pct = 8;
      repeat (300) send_event(random_event());
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d channel events and %0d checked samples over %0d negate settings,",
               events_sent, samples_checked, settings_used);
      $display("with a %0d-cycle output hold-off, a drain pause and a stall-free stretch.",
               HOLD_OFF_CYCLES);
      if (sample_mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
